FILE: src/des_pkg.sv
// DES constants and permutation/S-box functions shared by the cipher modules.
// No dependencies.
package des_pkg;

    localparam int unsigned BLOCK_W  = 64;
    localparam int unsigned KEY_W    = 64;
    localparam int unsigned ROUNDS   = 16;
    localparam int unsigned RKEY_W   = 48;
    localparam int unsigned CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_CIPHER_KEY   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DECRYPT_MODE = 1'b1;

    typedef logic [63:0] t_block;
    typedef logic [47:0] t_rkey;

    typedef logic [6:0] t_tab64 [64];

    localparam t_tab64 IP_TAB = '{
        58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
        62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
        57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
        61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};

    localparam t_tab64 FP_TAB = '{
        40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
        38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
        36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
        34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};

    localparam logic [5:0] E_TAB [48] = '{
        32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
        16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29,
        28,29,30,31,32,1};

    localparam logic [5:0] P_TAB [32] = '{
        16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
        2,8,24,14,32,27,3,9,    19,13,30,6,22,11,4,25};

    localparam logic [5:0] PC1_TAB [56] = '{
        57,49,41,33,25,17,9, 1,58,50,42,34,26,18,
        10,2,59,51,43,35,27, 19,11,3,60,52,44,36,
        63,55,47,39,31,23,15, 7,62,54,46,38,30,22,
        14,6,61,53,45,37,29, 21,13,5,28,20,12,4};

    localparam logic [5:0] PC2_TAB [48] = '{
        14,17,11,24,1,5, 3,28,15,6,21,10, 23,19,12,4,26,8, 16,7,27,20,13,2,
        41,52,31,37,47,55, 30,40,51,45,33,48, 44,49,39,56,34,53,
        46,42,50,36,29,32};

    localparam logic [1:0] ROT_TAB [16] = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};

    localparam logic [3:0] S_TAB [8][64] = '{
        '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7,
          0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
          4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0,
          15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
        '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10,
          3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
          0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15,
          13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
        '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8,
          13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
          13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7,
          1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
        '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15,
          13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
          10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4,
          3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
        '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9,
          14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
          4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14,
          11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
        '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11,
          10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
          9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6,
          4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
        '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1,
          13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
          1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2,
          6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
        '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7,
          1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
          7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8,
          2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

    function automatic logic [63:0] perm_ip(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = v[64 - int'(IP_TAB[i])];
        return r;
    endfunction

    function automatic logic [63:0] perm_fp(input logic [63:0] v);
        logic [63:0] r;
        for (int i = 0; i < 64; i++) r[63-i] = v[64 - int'(FP_TAB[i])];
        return r;
    endfunction

    function automatic logic [55:0] perm_pc1(input logic [63:0] v);
        logic [55:0] r;
        for (int i = 0; i < 56; i++) r[55-i] = v[64 - int'(PC1_TAB[i])];
        return r;
    endfunction

    function automatic logic [47:0] perm_pc2(input logic [55:0] v);
        logic [47:0] r;
        for (int i = 0; i < 48; i++) r[47-i] = v[56 - int'(PC2_TAB[i])];
        return r;
    endfunction

    // f function: expansion, key mix, S-boxes, P
    function automatic logic [31:0] round_f(input logic [31:0] r, input t_rkey k);
        logic [47:0] x;
        logic [31:0] s;
        logic [31:0] p;
        logic [5:0]  six;
        for (int i = 0; i < 48; i++) x[47-i] = r[32 - int'(E_TAB[i])];
        x = x ^ k;
        for (int i = 0; i < 8; i++) begin
            six = x[47-6*i -: 6];
            s[31-4*i -: 4] = S_TAB[i][{six[5], six[0], six[4:1]}];
        end
        for (int i = 0; i < 32; i++) p[31-i] = s[32 - int'(P_TAB[i])];
        return p;
    endfunction

endpackage

FILE: src/des_stream_if.sv
// Valid/ready stream channel carrying one DES block and its last flag.
// Depends on des_pkg.
interface des_stream_if;
    logic              valid;
    logic              ready;
    des_pkg::t_block   data;
    logic              last;

    modport source (output valid, output data, output last, input ready);
    modport sink   (input valid, input data, input last, output ready);
endinterface

FILE: src/des_block_cipher.sv
// DES ECB top level: key schedule registers and a 16-round stage pipeline.
// Depends on des_pkg and des_stream_if.
//
// Usage:
//   s_in  (sink)   : 64-bit block plus last flag, accepted on valid & ready.
//   s_out (source) : result block plus copied last flag.
//   Config: i_cfg_we writes register i_cfg_idx (0 = key, 1 = decrypt mode)
//   with i_cfg_data. Write only while the pipeline is empty.
// Pipeline: IP feeds stage 0, one Feistel round per register stage, the
//   final swap and FP sit before the output register. One block per cycle
//   sustained while the output register is free or being taken, set by the
//   round-per-stage pipeline.
// Round keys: derived from the key and mode into 16 registers, reloaded
//   every clock, order reversed for decryption, so data stages just pick a fixed key.
// Stall: the whole pipeline advances only when the output register is free
//   or being taken; nothing is dropped or duplicated. Input ready is the
//   same advance signal.
// Reset: clears all valid bits, the key to zero and the mode to encrypt;
//   round keys follow the reset key in the next cycle.
module des_block_cipher (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [des_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [des_pkg::KEY_W-1:0]          i_cfg_data,
    des_stream_if.sink                         s_in,
    des_stream_if.source                       s_out
);
    import des_pkg::*;

    logic [KEY_W-1:0] r_key;
    logic             r_decrypt;
    t_rkey            r_rk [ROUNDS];
    t_rkey            n_rk [ROUNDS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key     <= '0;
            r_decrypt <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CIPHER_KEY:   r_key     <= i_cfg_data;
                REG_DECRYPT_MODE: r_decrypt <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // key schedule: rotations are fixed per round, so this is wiring plus PC2
    always_comb begin
        logic [55:0] cd;
        logic [27:0] c, d;
        t_rkey       k [ROUNDS];
        cd = perm_pc1(r_key);
        c  = cd[55:28];
        d  = cd[27:0];
        for (int i = 0; i < ROUNDS; i++) begin
            if (ROT_TAB[i] == 2'd1) begin
                c = {c[26:0], c[27]};
                d = {d[26:0], d[27]};
            end else begin
                c = {c[25:0], c[27:26]};
                d = {d[25:0], d[27:26]};
            end
            k[i] = perm_pc2({c, d});
        end
        for (int i = 0; i < ROUNDS; i++)
            n_rk[i] = r_decrypt ? k[ROUNDS-1-i] : k[i];
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < ROUNDS; i++) r_rk[i] <= n_rk[i];
    end

    // pipeline: stage 0 holds IP output, stage i+1 holds result of round i
    logic        r_vld  [ROUNDS+1];
    logic [31:0] r_l    [ROUNDS+1];
    logic [31:0] r_r    [ROUNDS+1];
    logic        r_last [ROUNDS+1];
    logic        r_ovld;
    t_block      r_odata;
    logic        r_olast;
    logic        adv;
    logic [63:0] ip_out;

    assign adv         = !r_ovld || s_out.ready;
    assign s_in.ready  = adv;
    assign ip_out      = perm_ip(s_in.data);
    assign s_out.valid = r_ovld;
    assign s_out.data  = r_odata;
    assign s_out.last  = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= ROUNDS; i++) r_vld[i] <= 1'b0;
            r_ovld <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= s_in.valid;
            for (int i = 0; i < ROUNDS; i++) r_vld[i+1] <= r_vld[i];
            r_ovld <= r_vld[ROUNDS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_l[0]    <= ip_out[63:32];
            r_r[0]    <= ip_out[31:0];
            r_last[0] <= s_in.last;
            for (int i = 0; i < ROUNDS; i++) begin
                r_l[i+1]    <= r_r[i];
                r_r[i+1]    <= r_l[i] ^ round_f(r_r[i], r_rk[i]);
                r_last[i+1] <= r_last[i];
            end
            r_odata <= perm_fp({r_r[ROUNDS], r_l[ROUNDS]});
            r_olast <= r_last[ROUNDS];
        end
    end

    // a stalled output must hold its transaction
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld && !s_out.ready |=> r_ovld && $stable(r_odata) && $stable(r_olast))
        else $error("output changed while stalled");
    // ready tracks the output register state
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_ovld |-> s_in.ready)
        else $error("input stalled with empty output");
    // a transaction at the input reaches stage 0 on advance
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_in.valid && s_in.ready |=> r_vld[0])
        else $error("accepted transaction lost");
    // last stage drains into output register
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[ROUNDS] && adv |=> r_ovld)
        else $error("pipeline output lost");

endmodule

FILE: verif/des_block_cipher_checker.sv
// Scoreboard for des_block_cipher: tracks config writes, predicts each block.
// Depends on des_pkg and des_stream_if.
`timescale 1ns / 100ps

module des_block_cipher_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [des_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [des_pkg::KEY_W-1:0]     i_cfg_data,
    des_stream_if                         in_ch,
    des_stream_if                         out_ch,
    output int                            o_err_count,
    output int                            o_pending
);
    import des_pkg::*;

    typedef struct packed {
        t_block blk;
        logic   last;
    } t_cipher_out;

    logic [KEY_W-1:0] key_q;
    logic             decrypt_q;
    t_cipher_out      cipher_q[$];

    function automatic t_block des_crypt(input logic [63:0] key, input logic dec,
                                         input t_block blk);
        logic [55:0] cd;
        logic [27:0] c;
        logic [27:0] d;
        t_rkey       sched [16];
        t_rkey       k;
        logic [63:0] b;
        logic [63:0] res;
        logic [31:0] l;
        logic [31:0] r;
        logic [31:0] t;
        logic [31:0] f;
        logic [31:0] s;
        logic [47:0] x;
        logic [5:0]  six;
        for (int i = 0; i < 56; i++) cd[55-i] = key[64 - int'(PC1_TAB[i])];
        c = cd[55:28];
        d = cd[27:0];
        for (int i = 0; i < 16; i++) begin
            for (int n = 0; n < int'(ROT_TAB[i]); n++) begin
                c = {c[26:0], c[27]};
                d = {d[26:0], d[27]};
            end
            cd = {c, d};
            for (int j = 0; j < 48; j++) sched[i][47-j] = cd[56 - int'(PC2_TAB[j])];
        end
        for (int i = 0; i < 64; i++) b[63-i] = blk[64 - int'(IP_TAB[i])];
        l = b[63:32];
        r = b[31:0];
        for (int i = 0; i < 16; i++) begin
            k = dec ? sched[15-i] : sched[i];
            for (int j = 0; j < 48; j++) x[47-j] = r[32 - int'(E_TAB[j])];
            x = x ^ k;
            for (int j = 0; j < 8; j++) begin
                six = x[47-6*j -: 6];
                s[31-4*j -: 4] = S_TAB[j][{six[5], six[0], six[4:1]}];
            end
            for (int j = 0; j < 32; j++) f[31-j] = s[32 - int'(P_TAB[j])];
            t = r;
            r = l ^ f;
            l = t;
        end
        b = {r, l};
        for (int i = 0; i < 64; i++) res[63-i] = b[64 - int'(FP_TAB[i])];
        return res;
    endfunction

    assign o_pending = cipher_q.size();

    always @(posedge i_clk) begin
        t_cipher_out exp_item;
        if (!i_rst_n) begin
            key_q       <= '0;
            decrypt_q   <= 1'b0;
            o_err_count = 0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_CIPHER_KEY)   key_q     <= i_cfg_data;
                if (i_cfg_idx == REG_DECRYPT_MODE) decrypt_q <= i_cfg_data[0];
            end
            if (in_ch.valid && in_ch.ready)
                cipher_q.push_back('{des_crypt(key_q, decrypt_q, in_ch.data), in_ch.last});
            if (out_ch.valid && out_ch.ready) begin
                if (cipher_q.size() == 0) begin
                    $display("%0t: unexpected output block %h last %b",
                             $time, out_ch.data, out_ch.last);
                    o_err_count++;
                end else begin
                    exp_item = cipher_q.pop_front();
                    if (out_ch.data !== exp_item.blk) begin
                        $display("%0t: data mismatch expected %h actual %h",
                                 $time, exp_item.blk, out_ch.data);
                        o_err_count++;
                    end
                    if (out_ch.last !== exp_item.last) begin
                        $display("%0t: last mismatch expected %b actual %b",
                                 $time, exp_item.last, out_ch.last);
                        o_err_count++;
                    end
                end
            end
        end
    end
endmodule

FILE: verif/des_block_cipher_test.sv
// Testbench top for des_block_cipher: clock, reset, config and block stimulus.
// Depends on des_pkg, des_stream_if, des_block_cipher and its checker.
`timescale 1ns / 100ps

module des_block_cipher_test;
    import des_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 24;   // covers pipeline stages and output register, plus margin

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [KEY_W-1:0]     i_cfg_data;
    int                   err_count;
    int                   pending;
    int                   cycle_cnt = 0;
    int                   send_idle_pct;
    int                   recv_idle_pct;

    des_stream_if in_if ();
    des_stream_if out_if ();

    des_block_cipher dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .s_in       (in_if),
        .s_out      (out_if)
    );

    des_block_cipher_checker scoreboard (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .in_ch       (in_if),
        .out_ch      (out_if),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Watchdog: a hung pipeline or stuck handshake ends the run here.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver back-pressure, percentage set per phase.
    always @(posedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Register write; the round keys follow the key in the next cycle, so the
    // task waits out that update before the next transaction.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [KEY_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_cipher(input logic [63:0] key, input logic dec);
        write_reg(REG_CIPHER_KEY, key);
        write_reg(REG_DECRYPT_MODE, {63'b0, dec});
    endtask

    // One block transaction; valid stays high into the next call unless a
    // gap is drawn, so back-to-back blocks never toggle valid in one step.
    task automatic send_block(input t_block blk, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= blk;
        in_if.last  <= last;
        do @(posedge i_clk); while (!in_if.ready);
    endtask

    // Pipeline must be empty before config may change.
    task automatic drain();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++)
            send_block({$urandom, $urandom}, 1'($urandom_range(1)));
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= '0;
        i_cfg_data    <= '0;
        in_if.valid   <= 1'b0;
        in_if.data    <= '0;
        in_if.last    <= 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (3) @(posedge i_clk);

        // Directed: reset key, then data extremes with both last values.
        send_block(64'h0, 1'b0);
        send_block('1, 1'b1);
        send_block(64'h8000_0000_0000_0001, 1'b0);
        drain();

        // Classic textbook vector, encrypt then decrypt of its ciphertext.
        set_cipher(64'h1334_5779_9BBC_DFF1, 1'b0);
        send_block(64'h0123_4567_89AB_CDEF, 1'b1);
        send_block('1, 1'b0);
        drain();
        set_cipher(64'h1334_5779_9BBC_DFF1, 1'b1);
        send_block(64'h85E8_1354_0F0A_B405, 1'b1);
        send_block(64'h0, 1'b0);
        drain();

        // Weak and semi-weak keys get no special handling.
        set_cipher(64'h0101_0101_0101_0101, 1'b0);
        send_block(64'h0123_4567_89AB_CDEF, 1'b0);
        drain();
        set_cipher(64'h01FE_01FE_01FE_01FE, 1'b1);
        send_block(64'h5555_AAAA_5555_AAAA, 1'b1);
        drain();

        // All-ones key, parity bits only differ from the last setting.
        set_cipher('1, 1'b0);
        send_block(64'h0, 1'b1);
        send_block('1, 1'b0);
        drain();
        set_cipher(64'hFEFE_FEFE_FEFE_FEFE, 1'b1);
        send_block('1, 1'b1);
        drain();

        // Random phases: slow receiver, slow sender, then full rate.
        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 84 : 0;
            recv_idle_pct = (ph == 0) ? 84 : (ph == 1) ? 9 : 0;
            for (int s = 0; s < 2; s++) begin
                set_cipher({$urandom, $urandom}, 1'(s ^ (ph & 1)));
                run_random(300);
                drain();
            end
        end

        if (err_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
